FILE: rtl/srfp_pkg.sv
// Shared types and constants for the sensor reply frame parser.
// No dependencies; imported by the parser and its checker.
package srfp_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'hAA;
    localparam logic [7:0] TAIL_BYTE   = 8'hAB;
    localparam int unsigned PAYLOAD_LEN = 6;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned PAYLOAD_W   = 8 * PAYLOAD_LEN;
    localparam logic [7:0] REPLY_ID_RST = 8'hC0;

    typedef enum logic [2:0] {
        PH_HEAD  = 3'd0,
        PH_CMD   = 3'd1,
        PH_DATA  = 3'd2,
        PH_CHECK = 3'd3,
        PH_TAIL  = 3'd4
    } t_phase;

endpackage

FILE: rtl/sensor_reply_frame_parser.sv
// Sensor reply frame parser: header/command/payload/checksum/tail byte parser.
// Depends on srfp_pkg.

// One received byte per beat in, one result beat out per byte, one byte per
// clock sustained. The parse state, running sum and payload store update in
// the cycle a byte is accepted; the result lands in an output register backed
// by a one-beat skid register, so s_tready only drops when both are full.
// A result with m_tlast high marks a frame with good checksum and tail and
// carries its six payload bytes (first byte in bits 7:0); other results carry
// zero data. The reply id register resets to 0xC0 and should be written only
// while the parser is idle.
module sensor_reply_frame_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: expected command byte
    input  logic        i_reply_id_we,
    input  logic [7:0]  i_reply_id,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] payload
    output logic        m_tlast    // frame_done
);
    import srfp_pkg::*;

    logic [7:0]             r_reply_id;
    t_phase                 r_phase,   n_phase;
    logic [CNT_W-1:0]       r_count,   n_count;
    logic [7:0]             r_sum,     n_sum;
    logic [7:0]             r_store [PAYLOAD_LEN];
    logic                   store_we;

    logic                   r_out_valid, r_skid_valid;
    logic                   r_out_last,  r_skid_last;
    logic [PAYLOAD_W-1:0]   r_out_data,  r_skid_data;

    logic                   accept, take;
    logic                   done;
    logic [PAYLOAD_W-1:0]   packed_store;
    logic [PAYLOAD_W-1:0]   res_data;

    assign accept   = s_tvalid && s_tready;
    assign take     = r_out_valid && m_tready;
    assign s_tready = !r_skid_valid;

    always_comb begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            packed_store[8*i +: 8] = r_store[i];
        end
    end

    // next parse state for the byte on s_tdata
    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_sum    = r_sum;
        store_we = 1'b0;
        done     = 1'b0;
        unique case (r_phase)
            PH_HEAD: begin
                n_phase = (s_tdata == HDR_BYTE) ? PH_CMD : PH_HEAD;
            end
            PH_CMD: begin
                if (s_tdata == r_reply_id) begin
                    n_sum   = '0;
                    n_count = '0;
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_HEAD;
                end
            end
            PH_DATA: begin
                n_sum = r_sum + s_tdata;
                if (r_count < CNT_W'(PAYLOAD_LEN)) begin
                    store_we = 1'b1;
                    n_count  = r_count + CNT_W'(1);
                end
                if (n_count >= CNT_W'(PAYLOAD_LEN)) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                // on mismatch, reuse this byte as a possible header
                if (s_tdata == r_sum) begin
                    n_phase = PH_TAIL;
                end else begin
                    n_phase = (s_tdata == HDR_BYTE) ? PH_CMD : PH_HEAD;
                end
            end
            PH_TAIL: begin
                n_phase = PH_HEAD;
                done    = (s_tdata == TAIL_BYTE);
            end
            default: begin
                n_phase = PH_HEAD;
            end
        endcase
    end

    assign res_data = done ? packed_store : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_id <= REPLY_ID_RST;
        end else if (i_reply_id_we) begin
            r_reply_id <= i_reply_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD;
            r_count <= '0;
            r_sum   <= '0;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                r_store[i] <= '0;
            end
        end else if (accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_sum   <= n_sum;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                if (store_we && (r_count == CNT_W'(i))) begin
                    r_store[i] <= s_tdata;
                end
            end
        end
    end

    // output register with one-beat skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= r_skid_valid && accept;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_last <= r_skid_last;
                r_out_data <= r_skid_data;
                if (accept) begin
                    r_skid_last <= done;
                    r_skid_data <= res_data;
                end
            end else if (accept) begin
                r_out_last <= done;
                r_out_data <= res_data;
            end
        end else if (accept) begin
            r_skid_last <= done;
            r_skid_data <= res_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out_last;
    assign m_tdata  = r_out_data;

endmodule

FILE: rtl/srfp_checker.sv
// Port-level checks for sensor_reply_frame_parser, attached by bind.
// Depends on srfp_pkg and the parser's port list.
module srfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    import srfp_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // only a completed frame carries payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tlast |-> m_tdata == '0)
        else $error("payload nonzero without frame_done");

    // backpressure only when a result is waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // reset empties the result path
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("result path not empty after reset");

    // a byte accepted into an empty path shows up on the next cycle
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
        else $error("accepted byte produced no result");

endmodule

bind sensor_reply_frame_parser srfp_checker u_srfp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: tb/sensor_reply_frame_parser_test.sv
// Testbench for sensor_reply_frame_parser: drives serial bytes as beats, predicts each
// result beat with a frame tracker class and compares field by field.
// Depends on srfp_pkg and the parser RTL.
module sensor_reply_frame_parser_test;
    import srfp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_ITEMS   = 1600;
    localparam int unsigned PHASE_COUNT    = 4;

    typedef struct packed {
        logic                 done;
        logic [PAYLOAD_W-1:0] payload;
    } t_frame_result;

    typedef enum logic [2:0] {
        FK_GOOD,
        FK_BAD_CMD,
        FK_BAD_SUM,
        FK_BAD_TAIL,
        FK_CUT,
        FK_NOISE
    } t_frame_kind;

    // Tracks the parser state and queues the result each byte must produce.
    class frame_tracker;
        t_phase        hunt_phase;
        logic [2:0]    stored_count;
        logic [7:0]    byte_sum;
        logic [7:0]    payload_bytes [PAYLOAD_LEN];
        logic [7:0]    cmd_id;
        t_frame_result expected_frames [$];
        int unsigned   mismatches;

        function new();
            hunt_phase   = PH_HEAD;
            stored_count = '0;
            byte_sum     = '0;
            cmd_id       = REPLY_ID_RST;
            mismatches   = 0;
            foreach (payload_bytes[i]) payload_bytes[i] = '0;
        endfunction

        function void set_cmd_id(logic [7:0] v);
            cmd_id = v;
        endfunction

        function void take_byte(logic [7:0] b);
            t_frame_result r;
            r.done    = 1'b0;
            r.payload = '0;
            case (hunt_phase)
                PH_HEAD: begin
                    if (b == HDR_BYTE) hunt_phase = PH_CMD;
                    else hunt_phase = PH_HEAD;
                end
                PH_CMD: begin
                    if (b == cmd_id) begin
                        byte_sum     = '0;
                        stored_count = '0;
                        hunt_phase   = PH_DATA;
                    end else begin
                        hunt_phase = PH_HEAD;
                    end
                end
                PH_DATA: begin
                    byte_sum = byte_sum + b;
                    if (stored_count < PAYLOAD_LEN) begin
                        payload_bytes[stored_count] = b;
                        stored_count = stored_count + 3'd1;
                    end
                    if (stored_count >= PAYLOAD_LEN) hunt_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    // a bad checksum byte gets a second look as a header
                    if (b == byte_sum) hunt_phase = PH_TAIL;
                    else if (b == HDR_BYTE) hunt_phase = PH_CMD;
                    else hunt_phase = PH_HEAD;
                end
                PH_TAIL: begin
                    hunt_phase = PH_HEAD;
                    if (b == TAIL_BYTE) begin
                        r.done = 1'b1;
                        for (int i = 0; i < PAYLOAD_LEN; i++)
                            r.payload[8*i +: 8] = payload_bytes[i];
                    end
                end
                default: hunt_phase = PH_HEAD;
            endcase
            expected_frames.push_back(r);
        endfunction

        function void match_result(logic done, logic [PAYLOAD_W-1:0] payload);
            t_frame_result e;
            if (expected_frames.size() == 0) begin
                $error("result beat with nothing expected: frame_done %b payload %h",
                       done, payload);
                mismatches++;
                return;
            end
            e = expected_frames.pop_front();
            if (done !== e.done) begin
                $error("frame_done: expected %b, got %b", e.done, done);
                mismatches++;
            end
            if (payload !== e.payload) begin
                $error("payload: expected %h, got %h", e.payload, payload);
                mismatches++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_reply_id_we;
    logic [7:0]           i_reply_id;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [7:0] rx_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [PAYLOAD_W-1:0] m_tdata;   // [47:0] payload
    logic                 m_tlast;   // frame_done

    frame_tracker tracker = new();
    int unsigned  gap_pct;
    int unsigned  stall_pct;
    int unsigned  bytes_sent;
    int unsigned  quiet_cycles;

    sensor_reply_frame_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_reply_id_we (i_reply_id_we),
        .i_reply_id    (i_reply_id),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
            if (m_tvalid && m_tready) tracker.match_result(m_tlast, m_tdata);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one byte and hold it until the parser takes it.
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Hold off the sender until every expected result beat has come out.
    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tracker.expected_frames.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Call only after drain_results, at a falling edge with the parser idle.
    task automatic write_reply_id(input logic [7:0] v);
        i_reply_id_we <= 1'b1;
        i_reply_id    <= v;
        tracker.set_cmd_id(v);
        @(negedge i_clk);
        i_reply_id_we <= 1'b0;
    endtask

    function automatic logic [7:0] payload_value();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return HDR_BYTE;
            3:       return TAIL_BYTE;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        logic [7:0]  data [PAYLOAD_LEN];
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned pick;
        int unsigned n;
        t_frame_kind kind;
        pick = $urandom_range(0, 99);
        if (pick < 60) kind = FK_GOOD;
        else if (pick < 70) kind = FK_BAD_CMD;
        else if (pick < 80) kind = FK_BAD_SUM;
        else if (pick < 88) kind = FK_BAD_TAIL;
        else if (pick < 94) kind = FK_CUT;
        else kind = FK_NOISE;
        sum = '0;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            data[i] = payload_value();
            sum     = sum + data[i];
        end
        if (kind == FK_NOISE) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom));
            return;
        end
        send_byte(HDR_BYTE);
        if (kind == FK_BAD_CMD) begin
            b = $urandom_range(0, 3) == 0 ? HDR_BYTE : 8'($urandom);
            if (b == tracker.cmd_id) b = ~b;
            send_byte(b);
            return;
        end
        send_byte(tracker.cmd_id);
        n = (kind == FK_CUT) ? $urandom_range(0, PAYLOAD_LEN - 1) : PAYLOAD_LEN;
        for (int i = 0; i < n; i++) send_byte(data[i]);
        if (kind == FK_CUT) return;
        if (kind == FK_BAD_SUM) begin
            b = $urandom_range(0, 1) == 0 ? HDR_BYTE : 8'($urandom);
            if (b == sum) b = sum + 8'd1;
            send_byte(b);
            return;
        end
        send_byte(sum);
        if (kind == FK_BAD_TAIL) begin
            b = $urandom_range(0, 1) == 0 ? HDR_BYTE : 8'($urandom);
            if (b == TAIL_BYTE) b = b ^ 8'h01;
            send_byte(b);
            return;
        end
        send_byte(TAIL_BYTE);
    endtask

    initial begin
        logic [7:0]  phase_ids [PHASE_COUNT];
        int unsigned phase_gap [PHASE_COUNT];
        int unsigned phase_stall [PHASE_COUNT];
        int unsigned target;
        i_rst_n       = 1'b0;
        i_reply_id_we = 1'b0;
        i_reply_id    = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        gap_pct       = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        phase_ids     = '{8'h00, 8'hFF, HDR_BYTE, 8'($urandom)};
        phase_gap     = '{0, 51, 0, 34};
        phase_stall   = '{0, 0, 51, 34};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset reply id: a header byte in the command slot drops back to hunting
        // and is not taken as a new header.
        send_byte(HDR_BYTE);
        send_byte(HDR_BYTE);
        send_byte(REPLY_ID_RST);
        // Good checksum, then 0xAA in the tail slot: no frame, and no restart.
        send_byte(HDR_BYTE);
        send_byte(REPLY_ID_RST);
        repeat (PAYLOAD_LEN) send_byte(8'h00);
        send_byte(8'h00);
        send_byte(HDR_BYTE);
        // Checksum byte 0xAA is wrong, so it gets rescanned as the next header.
        send_byte(HDR_BYTE);
        send_byte(REPLY_ID_RST);
        repeat (PAYLOAD_LEN) send_byte(8'hFF);
        send_byte(HDR_BYTE);
        send_byte(REPLY_ID_RST);
        repeat (PAYLOAD_LEN) send_byte(8'hFF);
        send_byte(8'hFA);
        send_byte(TAIL_BYTE);
        drain_results();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            gap_pct   = phase_gap[ph];
            stall_pct = phase_stall[ph];
            write_reply_id(phase_ids[ph]);
            target = bytes_sent + RANDOM_ITEMS / PHASE_COUNT;
            while (bytes_sent < target) begin
                send_random_frame();
                if ($urandom_range(0, 39) == 0) drain_results();
            end
            drain_results();
        end

        repeat (16) @(negedge i_clk);
        if (tracker.mismatches == 0 && tracker.expected_frames.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
